// ===== hdl/dcfb_pkg.sv =====
// Shared types and constants for the daisy-chain frame buffer.
// Depends on nothing; all files but dcfb_ram refer to it by scoped names.
`default_nettype none

package dcfb_pkg;

    localparam int BUFFER_BYTES_DEF      = 4096;
    localparam int PACKET_DATA_BYTES_DEF = 64;

    localparam int BYTE_W      = 8;
    localparam int READ_ADDR_W = 12;
    localparam int CFG_IDX_W   = 1;

    // Smallest buffer is 64 bytes, so at most 64 multiples of it fit in a
    // 12-bit read address: six conditional subtractions reduce any address.
    localparam int READ_WRAP_STEPS = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_CODE  = 1'd1;

    localparam logic [BYTE_W-1:0] WRITE_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] SWAP_CODE_RST  = 8'd2;

    // What the output stage needs to know about a request in flight.
    typedef struct packed {
        logic is_read;   // display read of the front buffer
        logic is_fwd;    // write packet data byte, old byte goes downstream
        logic strobe;    // this byte swapped the buffers
        logic sel_b;     // which bank's read data belongs to this request
        logic zero;      // entry never written since reset, reads as zero
    } s1_info_t;

endpackage

`default_nettype wire

// ===== hdl/daisy_chain_frame_buffer.sv =====
// Top level of the daisy-chain frame buffer: two frame banks, control and
// output stage. Depends on dcfb_pkg, dcfb_ram, dcfb_ctrl and dcfb_out.
//
//   Port group   Handshake              Carries
//   ----------   --------------------   ------------------------------------------
//   input        in_valid / in_ready    mode, rx_byte, read_address
//   result       out_valid / out_ready  forward_valid, forward_byte, swap_strobe,
//                                       read_data
//   config       cfg_we (no wait)       cfg_index, cfg_data
//
// One request is taken per cycle unless the output stalls; each bank has one
// read and one write port, and a link byte uses one read and one write of the
// back bank in the same cycle. Results pass stage one, then the output register.
// No clearing pass after reset: a fill count per bank marks the written prefix,
// and entries beyond it read as zero, so requests are taken from the first cycle.
// A stalled result holds the output register while one more request is taken.
`default_nettype none

module daisy_chain_frame_buffer #(
    parameter int BUFFER_BYTES      = dcfb_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_DATA_BYTES = dcfb_pkg::PACKET_DATA_BYTES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [dcfb_pkg::BYTE_W-1:0]       rx_byte,
    input  wire logic [dcfb_pkg::READ_ADDR_W-1:0]  read_address,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   forward_valid,
    output logic      [dcfb_pkg::BYTE_W-1:0]       forward_byte,
    output logic                                   swap_strobe,
    output logic      [dcfb_pkg::BYTE_W-1:0]       read_data,
    input  wire logic                              cfg_we,
    input  wire logic [dcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcfb_pkg::BYTE_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    logic                        accept;
    logic                        a_we;
    logic                        b_we;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_addr;
    logic [dcfb_pkg::BYTE_W-1:0] rdata_a;
    logic [dcfb_pkg::BYTE_W-1:0] rdata_b;
    dcfb_pkg::s1_info_t          info;

    assign accept = in_valid && in_ready;

    dcfb_ctrl #(
        .BUFFER_BYTES      (BUFFER_BYTES),
        .PACKET_DATA_BYTES (PACKET_DATA_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .read_address (read_address),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .a_we         (a_we),
        .b_we         (b_we),
        .ram_re       (ram_re),
        .ram_addr     (ram_addr),
        .info         (info)
    );

    dcfb_ram #(
        .WIDTH (dcfb_pkg::BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_bank_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (ram_addr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (rdata_a)
    );

    dcfb_ram #(
        .WIDTH (dcfb_pkg::BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_bank_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (ram_addr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (rdata_b)
    );

    dcfb_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .info          (info),
        .rdata_a       (rdata_a),
        .rdata_b       (rdata_b),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .forward_valid (forward_valid),
        .forward_byte  (forward_byte),
        .swap_strobe   (swap_strobe),
        .read_data     (read_data)
    );

endmodule

`default_nettype wire

// ===== hdl/dcfb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module dcfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and a write to the same entry in one cycle return
    // the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dcfb_ctrl.sv =====
// Packet sequencing, configuration registers, buffer roles and fill counts;
// drives the two bank RAMs. Depends on dcfb_pkg.
`default_nettype none

module dcfb_ctrl #(
    parameter int BUFFER_BYTES      = dcfb_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_DATA_BYTES = dcfb_pkg::PACKET_DATA_BYTES_DEF,
    localparam int ADDR_W           = $clog2(BUFFER_BYTES)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic                              mode,
    input  wire logic [dcfb_pkg::BYTE_W-1:0]       rx_byte,
    input  wire logic [dcfb_pkg::READ_ADDR_W-1:0]  read_address,
    input  wire logic                              cfg_we,
    input  wire logic [dcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcfb_pkg::BYTE_W-1:0]       cfg_data,
    output logic                                   a_we,
    output logic                                   b_we,
    output logic                                   ram_re,
    output logic      [ADDR_W-1:0]                 ram_addr,
    output dcfb_pkg::s1_info_t                     info
);

    localparam int FILL_W = ADDR_W + 1;
    localparam int IDX_W  = $clog2(PACKET_DATA_BYTES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(PACKET_DATA_BYTES);
    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(BUFFER_BYTES - 1);
    localparam int RA_W = dcfb_pkg::READ_ADDR_W;

    logic [dcfb_pkg::BYTE_W-1:0] wr_code_reg, wr_code_next;
    logic [dcfb_pkg::BYTE_W-1:0] swap_code_reg, swap_code_next;
    logic [dcfb_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic [IDX_W-1:0]            pkt_idx_reg, pkt_idx_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic                        front_b_reg, front_b_next;
    logic [FILL_W-1:0]           fill_a_reg, fill_a_next;
    logic [FILL_W-1:0]           fill_b_reg, fill_b_next;

    logic              is_link;
    logic              is_cmd;
    logic              is_data;
    logic              last;
    logic              do_write;
    logic              do_swap;
    logic              grow_back;
    logic [RA_W-1:0]   wrapped;
    logic [ADDR_W-1:0] rd_addr;
    logic [FILL_W-1:0] fill_back;
    logic [FILL_W-1:0] fill_front;

    // Reduce the display address modulo the buffer size by subtracting
    // shifted copies of the size, largest first.
    always_comb
    begin
        wrapped = read_address;
        for (int j = dcfb_pkg::READ_WRAP_STEPS - 1; j >= 0; j--)
        begin
            if (32'(wrapped) >= (32'(BUFFER_BYTES) << j))
            begin
                wrapped = wrapped - RA_W'(32'(BUFFER_BYTES) << j);
            end
        end
        rd_addr = ADDR_W'(wrapped);
    end

    assign is_link  = accept && !mode;
    assign is_cmd   = is_link && (pkt_idx_reg == '0);
    assign is_data  = is_link && (pkt_idx_reg != '0);
    assign last     = (pkt_idx_reg == LAST_IDX);
    assign do_write = is_data && (cmd_reg == wr_code_reg);
    assign do_swap  = is_data && (cmd_reg != wr_code_reg) && (cmd_reg == swap_code_reg) && last;

    assign fill_back  = front_b_reg ? fill_a_reg : fill_b_reg;
    assign fill_front = front_b_reg ? fill_b_reg : fill_a_reg;

    // Each buffer is only ever written upwards from position zero, so the
    // entries written since reset form a prefix whose length is the fill count.
    assign grow_back = do_write && ({1'b0, pos_reg} == fill_back);

    // Bank A is the back buffer while B is in front, and the other way round.
    assign a_we     = do_write && front_b_reg;
    assign b_we     = do_write && !front_b_reg;
    assign ram_re   = accept;
    assign ram_addr = mode ? rd_addr : pos_reg;

    always_comb
    begin
        info         = '0;
        info.is_read = mode;
        info.is_fwd  = do_write;
        info.strobe  = do_swap;
        info.sel_b   = mode ? front_b_reg : !front_b_reg;
        info.zero    = mode ? ({1'b0, rd_addr} >= fill_front) : ({1'b0, pos_reg} >= fill_back);
    end

    always_comb
    begin
        wr_code_next   = wr_code_reg;
        swap_code_next = swap_code_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dcfb_pkg::REG_WRITE_CODE: wr_code_next   = cfg_data;
                dcfb_pkg::REG_SWAP_CODE:  swap_code_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        pkt_idx_next = pkt_idx_reg;
        pos_next     = pos_reg;
        front_b_next = front_b_reg;
        fill_a_next  = fill_a_reg;
        fill_b_next  = fill_b_reg;

        if (is_cmd)
        begin
            cmd_next     = rx_byte;
            pkt_idx_next = IDX_W'(1);
        end
        else if (is_data)
        begin
            pkt_idx_next = last ? '0 : pkt_idx_reg + IDX_W'(1);
        end

        if (do_write)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + ADDR_W'(1);
        end
        else if (do_swap)
        begin
            pos_next     = '0;
            front_b_next = !front_b_reg;
        end

        if (grow_back)
        begin
            if (front_b_reg)
            begin
                fill_a_next = fill_a_reg + FILL_W'(1);
            end
            else
            begin
                fill_b_next = fill_b_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_code_reg   <= dcfb_pkg::WRITE_CODE_RST;
            swap_code_reg <= dcfb_pkg::SWAP_CODE_RST;
            cmd_reg       <= '0;
            pkt_idx_reg   <= '0;
            pos_reg       <= '0;
            front_b_reg   <= 1'b0;
            fill_a_reg    <= '0;
            fill_b_reg    <= '0;
        end
        else
        begin
            wr_code_reg   <= wr_code_next;
            swap_code_reg <= swap_code_next;
            cmd_reg       <= cmd_next;
            pkt_idx_reg   <= pkt_idx_next;
            pos_reg       <= pos_next;
            front_b_reg   <= front_b_next;
            fill_a_reg    <= fill_a_next;
            fill_b_reg    <= fill_b_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dcfb_out.sv =====
// Read-data stage and output register with the result handshake; sets the
// input ready. Depends on dcfb_pkg.
`default_nettype none

module dcfb_out (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire dcfb_pkg::s1_info_t          info,
    input  wire logic [dcfb_pkg::BYTE_W-1:0] rdata_a,
    input  wire logic [dcfb_pkg::BYTE_W-1:0] rdata_b,
    output logic                             in_ready,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             forward_valid,
    output logic      [dcfb_pkg::BYTE_W-1:0] forward_byte,
    output logic                             swap_strobe,
    output logic      [dcfb_pkg::BYTE_W-1:0] read_data
);

    dcfb_pkg::s1_info_t s1_info_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               fwd_valid_reg;
    logic               strobe_reg;
    logic [dcfb_pkg::BYTE_W-1:0] fwd_byte_reg;
    logic [dcfb_pkg::BYTE_W-1:0] rd_data_reg;

    logic                        s1_move;
    logic [dcfb_pkg::BYTE_W-1:0] s1_data;

    // The RAM read data stays put while the stage holds, since no new
    // request is accepted then.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign s1_data  = s1_info_reg.zero ? '0 : (s1_info_reg.sel_b ? rdata_b : rdata_a);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (s1_move)
        begin
            fwd_valid_reg <= s1_info_reg.is_fwd;
            fwd_byte_reg  <= s1_info_reg.is_fwd ? s1_data : '0;
            strobe_reg    <= s1_info_reg.strobe;
            rd_data_reg   <= s1_info_reg.is_read ? s1_data : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign forward_valid = fwd_valid_reg;
    assign forward_byte  = fwd_byte_reg;
    assign swap_strobe   = strobe_reg;
    assign read_data     = rd_data_reg;

endmodule

`default_nettype wire

// ===== dv/tb_daisy_chain_frame_buffer.sv =====
// Self-checking testbench for the daisy-chain frame buffer.
// It runs a directed table, then random packet traffic, against a predictor of both banks.
// Depends on dcfb_pkg and daisy_chain_frame_buffer.
module tb_daisy_chain_frame_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W      = dcfb_pkg::BYTE_W;
    localparam int READ_ADDR_W = dcfb_pkg::READ_ADDR_W;
    localparam int CFG_IDX_W   = dcfb_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE = dcfb_pkg::REG_WRITE_CODE;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_CODE  = dcfb_pkg::REG_SWAP_CODE;
    localparam logic [BYTE_W-1:0]    WRITE_CODE_RST = dcfb_pkg::WRITE_CODE_RST;
    localparam logic [BYTE_W-1:0]    SWAP_CODE_RST  = dcfb_pkg::SWAP_CODE_RST;

    localparam int BUF_BYTES    = dcfb_pkg::BUFFER_BYTES_DEF;
    localparam int PKT_BYTES    = dcfb_pkg::PACKET_DATA_BYTES_DEF;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int NUM_ROWS     = 25;
    localparam int PHASE_ITEMS  = 60;

    localparam logic MODE_LINK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              fwd_valid;
        logic [BYTE_W-1:0] fwd_byte;
        logic              strobe;
        logic [BYTE_W-1:0] rdata;
    } link_result_t;

    localparam link_result_t QUIET    = '0;
    localparam link_result_t FWD_ZERO = {1'b1, 8'h00, 1'b0, 8'h00};
    localparam link_result_t SWAPPED  = {1'b0, 8'h00, 1'b1, 8'h00};

    typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

    // One row of the opening table: a run of requests or one register write.
    // For a register write the rx column carries the value.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic                   m;
        logic [BYTE_W-1:0]      rx;
        logic                   rx_inc;
        logic [READ_ADDR_W-1:0] addr;
        logic [6:0]             reps;
        logic                   typed;
        link_result_t           res;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   mode;
    logic [BYTE_W-1:0]      rx_byte;
    logic [READ_ADDR_W-1:0] read_address;
    logic                   out_valid;
    logic                   out_ready;
    logic                   forward_valid;
    logic [BYTE_W-1:0]      forward_byte;
    logic                   swap_strobe;
    logic [BYTE_W-1:0]      read_data;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    // Predictor state.
    logic [BYTE_W-1:0] bank_a [BUF_BYTES];
    logic [BYTE_W-1:0] bank_b [BUF_BYTES];
    int                pkt_index;
    logic [BYTE_W-1:0] cur_cmd;
    int                wr_pos;
    bit                front_is_b;
    logic [BYTE_W-1:0] write_code;
    logic [BYTE_W-1:0] swap_code;

    link_result_t due_responses [$];
    plan_row_t    opening_plan [NUM_ROWS];

    bit steady;
    int n_fail;
    int n_requests;
    int n_writes;
    int n_wraps;
    int n_swaps;
    int n_reads;
    int n_settings;

    daisy_chain_frame_buffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .rx_byte       (rx_byte),
        .read_address  (read_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .forward_valid (forward_valid),
        .forward_byte  (forward_byte),
        .swap_strobe   (swap_strobe),
        .read_data     (read_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: drops out_ready at random, with a chance of 9 in 100, never in a steady stretch.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    // Works out the response to one accepted request and advances the buffer state.
    function automatic link_result_t frame_buffer_response(
        input logic                   m,
        input logic [BYTE_W-1:0]      rx,
        input logic [READ_ADDR_W-1:0] addr
    );
        link_result_t r;
        bit           is_last;
        int           pos;
        r = QUIET;
        if (m == MODE_READ)
        begin
            r.rdata = front_is_b ? bank_b[int'(addr) % BUF_BYTES]
                                 : bank_a[int'(addr) % BUF_BYTES];
            n_reads++;
        end
        else if (pkt_index == 0)
        begin
            cur_cmd   = rx;
            pkt_index = 1;
        end
        else
        begin
            is_last = (pkt_index >= PKT_BYTES);
            // The write code wins when both registers hold the same value.
            if (cur_cmd == write_code)
            begin
                pos         = wr_pos % BUF_BYTES;
                r.fwd_valid = 1'b1;
                if (front_is_b)
                begin
                    r.fwd_byte  = bank_a[pos];
                    bank_a[pos] = rx;
                end
                else
                begin
                    r.fwd_byte  = bank_b[pos];
                    bank_b[pos] = rx;
                end
                wr_pos = (pos + 1) % BUF_BYTES;
                n_writes++;
                if (wr_pos == 0)
                    n_wraps++;
            end
            else if (cur_cmd == swap_code && is_last)
            begin
                front_is_b = !front_is_b;
                wr_pos     = 0;
                r.strobe   = 1'b1;
                n_swaps++;
            end
            pkt_index = is_last ? 0 : pkt_index + 1;
        end
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records its response.
    task automatic send_request(
        input logic                   m,
        input logic [BYTE_W-1:0]      rx,
        input logic [READ_ADDR_W-1:0] addr,
        input bit                     typed,
        input link_result_t           typed_res
    );
        link_result_t r;
        if (!steady && $urandom_range(99) < 9)
        begin
            repeat ($urandom_range(2, 1))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        mode         <= m;
        rx_byte      <= rx;
        read_address <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        r = frame_buffer_response(m, rx, addr);
        due_responses.push_back(typed ? typed_res : r);
        n_requests++;
    endtask

    // Holds off the sender until every response is back and the pipeline is empty.
    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_code_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_WRITE_CODE)
            write_code = val;
        else
            swap_code = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random packet traffic under one pair of command codes. Packets are mostly
    // write and swap packets with random content; display reads fall in between.
    task automatic run_phase(
        input logic [BYTE_W-1:0] wcode,
        input logic [BYTE_W-1:0] scode,
        input int                quota,
        input int                read_pct,
        input int                write_pct,
        input int                swap_pct
    );
        int                     pick;
        logic [BYTE_W-1:0]      rx;
        logic [READ_ADDR_W-1:0] addr;
        settle_pipeline();
        write_code_reg(REG_WRITE_CODE, wcode);
        write_code_reg(REG_SWAP_CODE, scode);
        n_settings++;
        for (int i = 0; i < quota; i++)
        begin
            case ($urandom_range(3))
                0, 1:    addr = READ_ADDR_W'($urandom_range(255));
                2:       addr = READ_ADDR_W'($urandom_range(4095));
                default: addr = READ_ADDR_W'($urandom_range(4095, 3840));
            endcase
            rx = BYTE_W'($urandom_range(255));
            if ($urandom_range(99) < read_pct)
                send_request(MODE_READ, rx, addr, 1'b0, QUIET);
            else
            begin
                if (pkt_index == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < write_pct)
                        rx = write_code;
                    else if (pick < write_pct + swap_pct)
                        rx = swap_code;
                end
                send_request(MODE_LINK, rx, addr, 1'b0, QUIET);
            end
            if ($urandom_range(199) == 0)
                settle_pipeline();
        end
    endtask

    always @(posedge clk)
    begin : response_check
        link_result_t seen;
        link_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {forward_valid, forward_byte, swap_strobe, read_data};
            if (due_responses.size() == 0)
            begin
                n_fail++;
                $display("%0t: response with none outstanding, got %05h", $realtime, seen);
            end
            else
            begin
                want = due_responses.pop_front();
                if (seen !== want)
                begin
                    n_fail++;
                    $display("%0t: expected %05h, got %05h", $realtime, want, seen);
                end
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] wc;
        logic [BYTE_W-1:0] sc;
        plan_row_t         row;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_LINK;
        rx_byte      = '0;
        read_address = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WRITE_CODE;
        cfg_data     = '0;
        steady       = 1'b0;
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            bank_a[i] = '0;
            bank_b[i] = '0;
        end
        pkt_index  = 0;
        cur_cmd    = '0;
        wr_pos     = 0;
        front_is_b = 1'b0;
        write_code = WRITE_CODE_RST;
        swap_code  = SWAP_CODE_RST;

        opening_plan = '{
            // Reads of the unwritten front bank after reset.
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'h00, 1'b0, 12'd0,    7'd1,  1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'hFF, 1'b0, 12'd4095, 7'd1,  1'b1, QUIET},
            // A full write packet: every displaced byte is still zero.
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, WRITE_CODE_RST, 1'b0, 12'hFFF, 7'd1, 1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'hFF, 1'b0, 12'd0,    7'd1,  1'b1, FWD_ZERO},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h00, 1'b1, 12'd0,    7'd62, 1'b1, FWD_ZERO},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'hA5, 1'b0, 12'd0,    7'd1,  1'b1, FWD_ZERO},
            // A swap packet strobes only on its last byte.
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, SWAP_CODE_RST, 1'b0, 12'd0, 7'd1, 1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h5A, 1'b1, 12'd0,    7'd63, 1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h00, 1'b0, 12'd0,    7'd1,  1'b1, SWAPPED},
            // The written bank is now in front.
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'h00, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'h00, 1'b0, 12'd63,   7'd1,  1'b0, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'h00, 1'b0, 12'd64,   7'd1,  1'b1, QUIET},
            // A packet with an unknown command is dropped.
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h77, 1'b0, 12'd0,    7'd1,  1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'hFF, 1'b1, 12'd0,    7'd64, 1'b1, QUIET},
            // Both codes equal: the packet writes.
            '{ROW_REG, REG_WRITE_CODE, MODE_LINK, 8'hFF, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REG, REG_SWAP_CODE,  MODE_LINK, 8'hFF, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'hFF, 1'b0, 12'd0,    7'd1,  1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h80, 1'b1, 12'd0,    7'd64, 1'b0, QUIET},
            // The write code changes partway through a swap packet.
            '{ROW_REG, REG_WRITE_CODE, MODE_LINK, 8'h00, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REG, REG_SWAP_CODE,  MODE_LINK, 8'h10, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h10, 1'b0, 12'd0,    7'd1,  1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'h33, 1'b1, 12'd0,    7'd20, 1'b1, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_READ, 8'h00, 1'b0, 12'd1,    7'd1,  1'b0, QUIET},
            '{ROW_REG, REG_WRITE_CODE, MODE_LINK, 8'h10, 1'b0, 12'd0,    7'd1,  1'b0, QUIET},
            '{ROW_REQ, REG_WRITE_CODE, MODE_LINK, 8'hC3, 1'b1, 12'd0,    7'd44, 1'b0, QUIET}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening_plan[i])
        begin
            row = opening_plan[i];
            if (row.kind == ROW_REG)
            begin
                settle_pipeline();
                write_code_reg(row.reg_idx, row.rx);
            end
            else
            begin
                for (int k = 0; k < int'(row.reps); k++)
                    send_request(row.m, row.rx + (row.rx_inc ? BYTE_W'(k) : BYTE_W'(0)),
                                 row.addr, row.typed, row.res);
            end
        end

        run_phase(WRITE_CODE_RST, SWAP_CODE_RST, PHASE_ITEMS, 12, 50, 30);
        run_phase(8'h00, 8'hFF, PHASE_ITEMS, 12, 50, 30);
        steady = 1'b1;
        run_phase(8'hFF, 8'h00, PHASE_ITEMS, 12, 50, 30);
        steady = 1'b0;
        wc = BYTE_W'($urandom_range(255));
        run_phase(wc, wc, PHASE_ITEMS, 12, 40, 40);
        run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), PHASE_ITEMS,
                  12, 45, 35);
        // Write packets only, with display reads rare.
        wc = BYTE_W'($urandom_range(255));
        sc = wc ^ BYTE_W'($urandom_range(255, 1));
        run_phase(wc, sc, PHASE_ITEMS, 3, 100, 0);
        run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), PHASE_ITEMS,
                  25, 50, 30);

        settle_pipeline();
        repeat (8) @(posedge clk);
        if (due_responses.size() != 0)
            n_fail++;

        $display("Run covered %0d requests: %0d buffer writes with %0d position wraps,",
                 n_requests, n_writes, n_wraps);
        $display("%0d bank swaps and %0d display reads, under %0d command code settings.",
                 n_swaps, n_reads, n_settings + 3);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
